// File: design/pmdl_pkg.sv
// Shared types and constants for the port module debounce and lifecycle tracker.
package pmdl_pkg;

    localparam int PORTS   = 8;
    localparam int PORT_W  = 3;
    localparam int PORT_AW = $clog2(PORTS);
    localparam int TYPE_W  = 4;
    localparam int RUN_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ACT_W   = 4;

    localparam logic [TYPE_W-1:0] TYPE_EMPTY   = 4'd0;
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 4'd15;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS = 2'd1;

    localparam logic [RUN_W-1:0] STABLE_COUNT_RST = 8'd3;
    localparam logic [ACT_W-1:0] ACTIVE_PORTS_RST = 4'd8;

    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_PRESENT = 2'd1,
        PH_ACTIVE  = 2'd2,
        PH_FAULTED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FLT_NONE         = 2'd0,
        FLT_UNCLASSIFIED = 2'd1,
        FLT_BUS          = 2'd2,
        FLT_ATTACH       = 2'd3
    } fault_t;

    typedef enum logic {
        CTL_IDLE   = 1'b0,
        CTL_LOOKUP = 1'b1
    } ctl_state_t;

    typedef struct packed {
        phase_t              phase;
        fault_t              fault;
        logic [TYPE_W-1:0]   attached;
        logic [TYPE_W-1:0]   settled;
        logic [TYPE_W-1:0]   cand_type;
        logic [RUN_W-1:0]    cand_run;
    } port_rec_t;

    localparam int REC_W = $bits(port_rec_t);

endpackage

// File: design/pmdl_if.sv
// Channel interfaces: module-ID readings, port status results and register writes.
interface pmdl_rd_if;
    logic                           valid;
    logic                           ready;
    logic [pmdl_pkg::PORT_W-1:0]    port;
    logic                           reading_valid;
    logic [pmdl_pkg::TYPE_W-1:0]    mod_id;
    logic                           probe_req;
    logic                           probe_ok;
    logic                           attach_ok;

    modport source (output valid, port, reading_valid, mod_id, probe_req,
                    probe_ok, attach_ok, input ready);
    modport sink   (input valid, port, reading_valid, mod_id, probe_req,
                    probe_ok, attach_ok, output ready);
endinterface

interface pmdl_st_if;
    logic                           valid;
    logic                           ready;
    logic [pmdl_pkg::PORT_W-1:0]    port_out;
    logic [1:0]                     lifecycle;
    logic [1:0]                     fault_code;
    logic [pmdl_pkg::TYPE_W-1:0]    committed_out;
    logic [pmdl_pkg::RUN_W-1:0]     run_length;
    logic                           detach_event;
    logic                           probe_event;
    logic                           attach_event;

    modport source (output valid, port_out, lifecycle, fault_code, committed_out,
                    run_length, detach_event, probe_event, attach_event, input ready);
    modport sink   (input valid, port_out, lifecycle, fault_code, committed_out,
                    run_length, detach_event, probe_event, attach_event, output ready);
endinterface

interface pmdl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pmdl_pkg::CFG_IDX_W-1:0]     index;
    logic [pmdl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/pmdl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pmdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/port_module_debounce_lifecycle.sv
// Top level: per-port module-ID debounce and module lifecycle tracker.
//
//  channel | dir | transaction
//  --------+-----+----------------------------------------------------------
//  reading | in  | one module-ID reading for one port plus probe/attach answers
//  status  | out | status of the port after the reading (in-range ports only)
//  cfg     | in  | register write: 0 stable_count, 1 active_ports
//
//  An accepted reading reads the port record from the state RAM at acceptance;
//  the LOOKUP state then modifies it, writes it back and loads the status
//  register. The reading channel is not ready during LOOKUP, so a new reading
//  is taken only once the last has left it. Readings for ports at or above active_ports drop at acceptance.
//  After reset, per-port valid bits make every record read as empty. A stalled
//  status register holds the lookup stage, and with it the reading ready.
module port_module_debounce_lifecycle (
    input  logic        clk,
    input  logic        rst_n,
    pmdl_rd_if.sink     reading,
    pmdl_st_if.source   status,
    pmdl_cfg_if.sink    cfg
);

    import pmdl_pkg::*;

    // Configuration registers
    logic [RUN_W-1:0] stable_count_reg;
    logic [ACT_W-1:0] active_ports_reg;

    // Control
    ctl_state_t state_reg, state_next;
    logic       accept;
    logic       in_range;
    logic       advance;

    // Latched reading for the lookup state
    logic [PORT_W-1:0] it_port_reg;
    logic              it_valid_reg;
    logic [TYPE_W-1:0] it_type_reg;
    logic              it_need_probe_reg;
    logic              it_probe_ok_reg;
    logic              it_attach_ok_reg;

    // State memory and its per-port valid bits
    logic [PORTS-1:0]  ent_vld_reg;
    logic              rd_vld_reg;
    logic [REC_W-1:0]  ram_rdata;
    port_rec_t         cur_rec;
    port_rec_t         new_rec;

    // Step events
    logic ev_detach, ev_probe, ev_attach;

    // Status register
    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    port_rec_t         out_rec_reg;
    logic              out_detach_reg, out_probe_reg, out_attach_reg;

    // Configuration: always ready; the user must make writes land while the block is quiet (unchecked)
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg <= STABLE_COUNT_RST;
            active_ports_reg <= ACTIVE_PORTS_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_STABLE_COUNT)
            begin
                stable_count_reg <= cfg.data;
            end
            else if (cfg.index == CFG_ACTIVE_PORTS)
            begin
                active_ports_reg <= cfg.data[ACT_W-1:0];
            end
        end
    end

    // Accept a reading whenever the lookup stage is free; drop it if the
    // port is out of range.
    assign reading.ready = (state_reg == CTL_IDLE);
    assign accept        = reading.valid && reading.ready;
    assign in_range      = (32'(reading.port) < PORTS)
                        && ({1'b0, reading.port} < active_ports_reg);
    // Finish the lookup once the status register is free
    assign advance       = !out_valid_reg || status.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = CTL_LOOKUP;
                end
            end
            CTL_LOOKUP:
            begin
                if (advance)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Hold the reading for the lookup state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_port_reg       <= reading.port;
            it_valid_reg      <= reading.reading_valid;
            it_type_reg       <= reading.mod_id;
            it_need_probe_reg <= reading.probe_req;
            it_probe_ok_reg   <= reading.probe_ok;
            it_attach_ok_reg  <= reading.attach_ok;
        end
    end

    // Capture whether the entry has ever been written, alongside the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            rd_vld_reg <= ent_vld_reg[reading.port[PORT_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
        end
        else if (state_reg == CTL_LOOKUP && advance)
        begin
            ent_vld_reg[it_port_reg[PORT_AW-1:0]] <= 1'b1;
        end
    end

    pmdl_ram #(
        .WIDTH (REC_W),
        .DEPTH (PORTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_reg == CTL_LOOKUP && advance),
        .waddr (it_port_reg[PORT_AW-1:0]),
        .wdata (new_rec),
        .re    (accept),
        .raddr (reading.port[PORT_AW-1:0]),
        .rdata (ram_rdata)
    );

    // A never-written entry reads as the reset record (all fields zero)
    assign cur_rec = rd_vld_reg ? port_rec_t'(ram_rdata) : '0;

    // Modify: debounce run, then commit a newly stable type
    always_comb
    begin
        new_rec   = cur_rec;
        ev_detach = 1'b0;
        ev_probe  = 1'b0;
        ev_attach = 1'b0;

        if (!it_valid_reg)
        begin
            new_rec.cand_run = '0;
        end
        else
        begin
            if (it_type_reg == cur_rec.cand_type)
            begin
                new_rec.cand_run = (cur_rec.cand_run == RUN_MAX)
                                 ? RUN_MAX : cur_rec.cand_run + 8'd1;
            end
            else
            begin
                new_rec.cand_type = it_type_reg;
                new_rec.cand_run  = 8'd1;
            end

            if (new_rec.cand_run < stable_count_reg)
            begin
                // Still settling: show presence or absence only while nothing is attached
                if (cur_rec.attached == TYPE_EMPTY)
                begin
                    new_rec.phase = (it_type_reg == TYPE_EMPTY) ? PH_EMPTY : PH_PRESENT;
                end
            end
            else if (it_type_reg != cur_rec.settled)
            begin
                new_rec.settled  = it_type_reg;
                ev_detach        = (cur_rec.attached != TYPE_EMPTY)
                                && (cur_rec.attached != TYPE_UNKNOWN);
                new_rec.attached = TYPE_EMPTY;

                priority if (it_type_reg == TYPE_EMPTY)
                begin
                    new_rec.phase = PH_EMPTY;
                    new_rec.fault = FLT_NONE;
                end
                else if (it_type_reg == TYPE_UNKNOWN)
                begin
                    new_rec.phase = PH_FAULTED;
                    new_rec.fault = FLT_UNCLASSIFIED;
                end
                else if (it_need_probe_reg && !it_probe_ok_reg)
                begin
                    ev_probe      = 1'b1;
                    new_rec.phase = PH_FAULTED;
                    new_rec.fault = FLT_BUS;
                end
                else
                begin
                    ev_probe  = it_need_probe_reg;
                    ev_attach = 1'b1;
                    if (!it_attach_ok_reg)
                    begin
                        new_rec.phase = PH_FAULTED;
                        new_rec.fault = FLT_ATTACH;
                    end
                    else
                    begin
                        new_rec.phase    = PH_ACTIVE;
                        new_rec.fault    = FLT_NONE;
                        new_rec.attached = it_type_reg;
                    end
                end
            end
        end
    end

    // Status register: load on lookup completion, drop on transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == CTL_LOOKUP && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CTL_LOOKUP && advance)
        begin
            out_port_reg   <= it_port_reg;
            out_rec_reg    <= new_rec;
            out_detach_reg <= ev_detach;
            out_probe_reg  <= ev_probe;
            out_attach_reg <= ev_attach;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.port_out      = out_port_reg;
    assign status.lifecycle     = out_rec_reg.phase;
    assign status.fault_code    = out_rec_reg.fault;
    assign status.committed_out = out_rec_reg.attached;
    assign status.run_length    = out_rec_reg.cand_run;
    assign status.detach_event  = out_detach_reg;
    assign status.probe_event   = out_probe_reg;
    assign status.attach_event  = out_attach_reg;

`ifndef ASSERT_OFF
    a_drop_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_range) |=> (state_reg == CTL_IDLE))
        else $error("out-of-range reading entered lookup");

    a_lookup_loads_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTL_LOOKUP && advance) |=> out_valid_reg)
        else $error("finished lookup did not load status");

    a_active_iff_attached: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> ((status.lifecycle == PH_ACTIVE)
                          == (status.committed_out != TYPE_EMPTY)))
        else $error("active lifecycle and attached type disagree");

    a_faulted_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.lifecycle == PH_FAULTED) |-> (status.fault_code != FLT_NONE))
        else $error("faulted port reports no fault code");
`endif

endmodule

// File: tb/lifecycle_monitor.sv
// Watches the reading, status and register channels, predicts each port status and compares it.
`timescale 1ns / 1ps

module lifecycle_monitor
    import pmdl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pmdl_rd_if     rd,
    pmdl_st_if     st,
    pmdl_cfg_if    cfg,
    output int     failures,
    output int     open_results
);

    typedef struct packed {
        logic [PORT_W-1:0] port;
        phase_t            lifecycle;
        fault_t            fault;
        logic [TYPE_W-1:0] committed;
        logic [RUN_W-1:0]  run;
        logic              detach;
        logic              probe;
        logic              attach;
    } port_status_t;

    // Register copies.
    logic [RUN_W-1:0] stable_q;
    logic [ACT_W-1:0] active_q;

    // Per-port record.
    phase_t            lc_state  [PORTS];
    fault_t            flt_state [PORTS];
    logic [TYPE_W-1:0] attached  [PORTS];
    logic [TYPE_W-1:0] settled   [PORTS];
    logic [TYPE_W-1:0] cand_type [PORTS];
    logic [RUN_W-1:0]  cand_run  [PORTS];

    port_status_t awaited_status [$];

    // Apply one reading to the port record; returns 1 when a status is due.
    function automatic bit advance_port(input logic [PORT_W-1:0] p, input logic rv,
                                        input logic [TYPE_W-1:0] mt, input logic np,
                                        input logic pok, input logic aok,
                                        output port_status_t s);
        logic det;
        logic prb;
        logic att;
        det = 1'b0;
        prb = 1'b0;
        att = 1'b0;
        s   = '0;
        if (int'(p) >= PORTS || int'(p) >= int'(active_q))
            return 1'b0;

        if (!rv)
        begin
            cand_run[p] = '0;
        end
        else
        begin
            if (mt == cand_type[p])
            begin
                if (cand_run[p] != RUN_MAX)
                    cand_run[p] = cand_run[p] + 1'b1;
            end
            else
            begin
                cand_type[p] = mt;
                cand_run[p]  = 8'd1;
            end

            if (cand_run[p] < stable_q)
            begin
                if (attached[p] == TYPE_EMPTY)
                    lc_state[p] = (mt == TYPE_EMPTY) ? PH_EMPTY : PH_PRESENT;
            end
            else if (mt != settled[p])
            begin
                settled[p] = mt;
                if (attached[p] != TYPE_EMPTY && attached[p] != TYPE_UNKNOWN)
                    det = 1'b1;
                attached[p] = TYPE_EMPTY;
                if (mt == TYPE_EMPTY)
                begin
                    lc_state[p]  = PH_EMPTY;
                    flt_state[p] = FLT_NONE;
                end
                else if (mt == TYPE_UNKNOWN)
                begin
                    lc_state[p]  = PH_FAULTED;
                    flt_state[p] = FLT_UNCLASSIFIED;
                end
                else if (np && !pok)
                begin
                    prb          = 1'b1;
                    lc_state[p]  = PH_FAULTED;
                    flt_state[p] = FLT_BUS;
                end
                else
                begin
                    prb = np;
                    att = 1'b1;
                    if (!aok)
                    begin
                        lc_state[p]  = PH_FAULTED;
                        flt_state[p] = FLT_ATTACH;
                    end
                    else
                    begin
                        lc_state[p]  = PH_ACTIVE;
                        flt_state[p] = FLT_NONE;
                        attached[p]  = mt;
                    end
                end
            end
        end

        s.port      = p;
        s.lifecycle = lc_state[p];
        s.fault     = flt_state[p];
        s.committed = attached[p];
        s.run       = cand_run[p];
        s.detach    = det;
        s.probe     = prb;
        s.attach    = att;
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: status %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        port_status_t exp_s;
        port_status_t new_s;
        if (!rst_n)
        begin
            stable_q = STABLE_COUNT_RST;
            active_q = ACTIVE_PORTS_RST;
            for (int i = 0; i < PORTS; i++)
            begin
                lc_state[i]  = PH_EMPTY;
                flt_state[i] = FLT_NONE;
                attached[i]  = TYPE_EMPTY;
                settled[i]   = TYPE_EMPTY;
                cand_type[i] = TYPE_EMPTY;
                cand_run[i]  = '0;
            end
            awaited_status.delete();
            failures     = 0;
            open_results = 0;
        end
        else
        begin
            // Results come from older readings, so compare before predicting.
            if (st.valid && st.ready)
            begin
                if (awaited_status.size() == 0)
                begin
                    $display("%0t: unexpected status: expected none, actual port %0d lc %0d",
                             $time, st.port_out, st.lifecycle);
                    failures++;
                end
                else
                begin
                    exp_s = awaited_status.pop_front();
                    compare_field("port_out", exp_s.port, st.port_out);
                    compare_field("lifecycle", exp_s.lifecycle, st.lifecycle);
                    compare_field("fault_code", exp_s.fault, st.fault_code);
                    compare_field("committed_out", exp_s.committed, st.committed_out);
                    compare_field("run_length", exp_s.run, st.run_length);
                    compare_field("detach_event", exp_s.detach, st.detach_event);
                    compare_field("probe_event", exp_s.probe, st.probe_event);
                    compare_field("attach_event", exp_s.attach, st.attach_event);
                end
            end

            if (rd.valid && rd.ready)
            begin
                if (advance_port(rd.port, rd.reading_valid, rd.mod_id, rd.probe_req,
                                 rd.probe_ok, rd.attach_ok, new_s))
                    awaited_status.push_back(new_s);
            end

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_STABLE_COUNT)
                    stable_q = cfg.data[RUN_W-1:0];
                else if (cfg.index == CFG_ACTIVE_PORTS)
                    active_q = cfg.data[ACT_W-1:0];
            end

            open_results = awaited_status.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, stimulus phases, handshake stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import pmdl_pkg::*;

    // Register indexes past the end of the list; writes to them must do nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // A reading leaves the block through the status register after its lookup; allow a margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              rv;
        logic [TYPE_W-1:0] mt;
        logic              np;
        logic              pok;
        logic              aok;
    } reading_t;

    logic clk;
    logic rst_n;

    pmdl_rd_if  rd_ch ();
    pmdl_st_if  st_ch ();
    pmdl_cfg_if cfg_ch ();

    int failures;
    int open_results;
    int cycle_count = 0;

    // Stall percentages for the current phase.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Mirror of the register settings that the stimulus needs to pick ports and runs.
    int cur_stable = 3;
    int cur_active = 8;

    // Handshakes seen at the last rising edge, read back at the falling edge.
    logic rd_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    port_module_debounce_lifecycle dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (rd_ch),
        .status  (st_ch),
        .cfg     (cfg_ch)
    );

    lifecycle_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd           (rd_ch),
        .st           (st_ch),
        .cfg          (cfg_ch),
        .failures     (failures),
        .open_results (open_results)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rd_taken  <= rd_ch.valid & rd_ch.ready;
        cfg_taken <= cfg_ch.valid & cfg_ch.ready;
    end

    // Drop the status ready at random according to the current phase.
    always @(negedge clk)
    begin
        st_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop so a hung handshake cannot run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic reading_t make_reading(input int p, input int rv, input int mt,
                                              input int np, input int pok, input int aok);
        reading_t r;
        r.port = p[PORT_W-1:0];
        r.rv   = rv[0];
        r.mt   = mt[TYPE_W-1:0];
        r.np   = np[0];
        r.pok  = pok[0];
        r.aok  = aok[0];
        return r;
    endfunction

    // Favor the empty and unknown codes so that both special types commit often.
    function automatic int pick_type();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return TYPE_EMPTY;
        else if (roll < 35)
            return TYPE_UNKNOWN;
        return $urandom_range(1, 14);
    endfunction

    // Present one reading and hold it until the block takes the transaction.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_reading(input reading_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            rd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rd_ch.valid         <= 1'b1;
        rd_ch.port          <= r.port;
        rd_ch.reading_valid <= r.rv;
        rd_ch.mod_id        <= r.mt;
        rd_ch.probe_req     <= r.np;
        rd_ch.probe_ok      <= r.pok;
        rd_ch.attach_ok     <= r.aok;
        @(negedge clk);
        while (!rd_taken)
            @(negedge clk);
    endtask

    // Repeat one valid reading to build a debounce run.
    task automatic send_run(input int p, input int mt, input int np, input int pok,
                            input int aok, input int count);
        repeat (count)
            send_reading(make_reading(p, 1, mt, np, pok, aok));
    endtask

    // Hold off new readings until every status has arrived, then let the
    // pipeline empty of dropped readings that produce no status.
    task automatic wait_for_idle();
        rd_ch.valid <= 1'b0;
        @(negedge clk);
        while (open_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Write one register and track the effective setting for port and run choice.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        int act;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        if (idx == CFG_STABLE_COUNT)
            cur_stable = value & 8'hFF;
        else if (idx == CFG_ACTIVE_PORTS)
        begin
            act = value & 4'hF;
            cur_active = (act > PORTS) ? PORTS : act;
        end
    endtask

    // Mostly debounce runs of random content, a few broken by bad reads,
    // mixed with fully random noise. Only in-range readings count toward target.
    task automatic send_random_traffic(input int target);
        int       counted;
        int       p;
        int       mt;
        int       np;
        int       pok;
        int       aok;
        int       eff;
        int       len;
        reading_t r;
        counted = 0;
        while (counted < target)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    p = $urandom_range(0, PORTS - 1);
                else
                    p = $urandom_range(0, cur_active - 1);
                mt  = pick_type();
                np  = $urandom_range(0, 1);
                pok = ($urandom_range(0, 3) != 0);
                aok = ($urandom_range(0, 3) != 0);
                eff = (cur_stable == 0) ? 1 : cur_stable;
                len = $urandom_range(1, (eff + 2 > 12) ? 12 : eff + 2);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 8)
                        r = make_reading(p, 0, $urandom_range(0, 15), $urandom_range(0, 1),
                                         $urandom_range(0, 1), $urandom_range(0, 1));
                    else
                        r = make_reading(p, 1, mt, np, pok, aok);
                    send_reading(r);
                    if (p < cur_active)
                        counted++;
                end
            end
            else
            begin
                r = make_reading($urandom_range(0, PORTS - 1), $urandom_range(0, 1),
                                 $urandom_range(0, 15), $urandom_range(0, 1),
                                 $urandom_range(0, 1), $urandom_range(0, 1));
                send_reading(r);
                if (r.port < cur_active)
                    counted++;
            end
        end
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n               = 1'b0;
        rd_ch.valid         = 1'b0;
        rd_ch.port          = '0;
        rd_ch.reading_valid = 1'b0;
        rd_ch.mod_id        = '0;
        rd_ch.probe_req     = 1'b0;
        rd_ch.probe_ok      = 1'b0;
        rd_ch.attach_ok     = 1'b0;
        st_ch.ready         = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;

        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings (stable 3, all ports), no stalls.
        idle_pct  = 0;
        stall_pct = 0;
        // Empty run on a port that already reads empty: stable but resolved.
        send_run(0, TYPE_EMPTY, 0, 0, 0, 3);
        // Probe and attach succeed, then the module leaves and is detached.
        send_run(1, 5, 1, 1, 1, 3);
        send_run(1, TYPE_EMPTY, 0, 0, 0, 3);
        // Unknown id faults; one reading of another type then shows presence, the fault code kept.
        send_run(2, TYPE_UNKNOWN, 1, 1, 1, 3);
        send_reading(make_reading(2, 1, 4, 0, 0, 0));
        // Probe fails: bus fault, no attach attempted.
        send_run(3, 7, 1, 0, 1, 3);
        // Probe not needed, so its answer is ignored; the attach fails.
        send_run(4, 9, 0, 0, 0, 3);
        // A bad read in the middle clears the run.
        send_reading(make_reading(5, 1, 3, 0, 1, 1));
        send_reading(make_reading(5, 0, 14, 1, 1, 1));
        send_run(5, 3, 0, 1, 1, 3);
        // Highest port, highest real type; one more reading keeps it active.
        send_run(7, 14, 1, 1, 1, 3);
        send_reading(make_reading(7, 1, 1, 1, 1, 1));
        wait_for_idle();

        // Commit on the first reading, all ports, no stalls.
        write_register(CFG_STABLE_COUNT, 1);
        write_register(CFG_ACTIVE_PORTS, 8);
        send_random_traffic(250);
        wait_for_idle();

        // Five ports, sender idle most of the time.
        write_register(CFG_STABLE_COUNT, 2);
        write_register(CFG_ACTIVE_PORTS, 5);
        idle_pct = 66;
        send_random_traffic(300);
        wait_for_idle();

        // No ports in use: every reading is dropped without a status.
        write_register(CFG_ACTIVE_PORTS, 0);
        write_register(CFG_STABLE_COUNT, 4);
        idle_pct = 0;
        repeat (20)
            send_reading(make_reading($urandom_range(0, PORTS - 1), $urandom_range(0, 1),
                                      $urandom_range(0, 15), $urandom_range(0, 1),
                                      $urandom_range(0, 1), $urandom_range(0, 1)));
        wait_for_idle();

        // Writes past the register list must leave both settings alone.
        write_register(CFG_SPARE_A, 8'hFF);
        write_register(CFG_SPARE_B, 8'h00);
        // Stable count of zero acts as one; high bits of the port count are dropped.
        write_register(CFG_STABLE_COUNT, 0);
        write_register(CFG_ACTIVE_PORTS, 8'hF3);
        stall_pct = 66;
        send_random_traffic(300);
        wait_for_idle();

        // Longest debounce and a port count above the port total.
        write_register(CFG_STABLE_COUNT, 255);
        write_register(CFG_ACTIVE_PORTS, 8'h0C);
        idle_pct  = 11;
        stall_pct = 11;
        // Reach the stable count exactly, then saturate the run.
        send_run(0, 6, 1, 1, 1, 260);
        send_random_traffic(100);
        wait_for_idle();

        write_register(CFG_STABLE_COUNT, 5);
        write_register(CFG_ACTIVE_PORTS, 8);
        send_random_traffic(100);
        wait_for_idle();

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
